>>> design/bhdti_pkg.sv
// Shared constants and the arctangent table for the half/difference angle indexer.
package bhdti_pkg;

    // Default block parameters.
    localparam int HALF_POLAR_BINS_DEF  = 90;
    localparam int DIFF_POLAR_BINS_DEF  = 90;
    localparam int DIFF_AZIMUTH_RES_DEF = 360;
    localparam int ANGLE_BITS_DEF       = 16;

    // CORDIC arithmetic.
    localparam int STEPS  = 30;
    localparam int QFRAC  = 30;
    localparam int TURN_W = 32;
    localparam int ROT_W  = 34;
    localparam int VEC_W  = 36;
    localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
    localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [TURN_W-1:0] QUARTER_HALF = 32'h2000_0000;

    // Binning and addressing.
    localparam int BIN_W    = 9;
    localparam int ADDR_W   = 32;
    localparam int SQ_SHIFT = 15;

    // Output field widths.
    localparam int HPB_W = 7;
    localparam int DPB_W = 7;
    localparam int DAB_W = 8;
    localparam int RED_W = 21;
    localparam int GRN_W = 22;
    localparam int BLU_W = 23;

    // atan(2^-i) in 2^32-per-turn units.
    function automatic logic [TURN_W-1:0] f_atan(input int idx);
        logic [TURN_W-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            24:      v = 32'h0000_0029;
            25:      v = 32'h0000_0014;
            26:      v = 32'h0000_000A;
            27:      v = 32'h0000_0005;
            28:      v = 32'h0000_0003;
            29:      v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

>>> design/bhdti_rot_cordic.sv
// Pipelined rotation CORDIC: cosine and sine of a turn-fraction angle.
module bhdti_rot_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [bhdti_pkg::TURN_W-1:0]        i_angle,
    output logic                                o_valid,
    output logic signed [bhdti_pkg::ROT_W-1:0]  o_cos,
    output logic signed [bhdti_pkg::ROT_W-1:0]  o_sin
);
    import bhdti_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [TURN_W-1:0] w_sum;
    logic [TURN_W-1:0] w_res;
    logic [1:0]        w_q;

    logic                    r_v [0:STEPS];
    logic signed [ROT_W-1:0] r_x [0:STEPS];
    logic signed [ROT_W-1:0] r_y [0:STEPS];
    logic signed [ROT_W-1:0] r_z [0:STEPS];
    logic [1:0]              r_q [0:STEPS];

    logic signed [ROT_W-1:0] n_cos, n_sin;
    logic                    r_vo;
    logic signed [ROT_W-1:0] r_cos, r_sin;

    // nearest quarter turn, residual in [-1/8, 1/8)
    assign w_sum = i_angle + QUARTER_HALF;
    assign w_q   = w_sum[TURN_W-1:TURN_W-2];
    assign w_res = i_angle - {w_q, {(TURN_W-2){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= ROT_W'(INV_GAIN);
            r_y[0] <= '0;
            r_z[0] <= ROT_W'($signed(w_res));
            r_q[0] <= w_q;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [ROT_W-1:0] ANG = ROT_W'(f_atan(i));
        logic signed [ROT_W-1:0] n_x, n_y, n_z;

        always_comb begin
            if (!r_z[i][ROT_W-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ANG;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
                r_q[i+1] <= r_q[i];
            end
        end
    end

    always_comb begin
        case (r_q[STEPS])
            QUAD_0: begin
                n_cos = r_x[STEPS];
                n_sin = r_y[STEPS];
            end
            QUAD_1: begin
                n_cos = -r_y[STEPS];
                n_sin = r_x[STEPS];
            end
            QUAD_2: begin
                n_cos = -r_x[STEPS];
                n_sin = -r_y[STEPS];
            end
            default: begin
                n_cos = r_y[STEPS];
                n_sin = -r_x[STEPS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_valid = r_vo;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

>>> design/bhdti_vec_cordic.sv
// Pipelined vectoring CORDIC: angle and gain-corrected magnitude, with a follower pair.
module bhdti_vec_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [bhdti_pkg::VEC_W-1:0]  i_x,
    input  logic signed [bhdti_pkg::VEC_W-1:0]  i_y,
    input  logic signed [bhdti_pkg::VEC_W-1:0]  i_fx,
    input  logic signed [bhdti_pkg::VEC_W-1:0]  i_fy,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic signed [bhdti_pkg::VEC_W-1:0]  o_x,
    output logic signed [bhdti_pkg::VEC_W-1:0]  o_fx,
    output logic signed [bhdti_pkg::VEC_W-1:0]  o_fy,
    output logic [bhdti_pkg::TURN_W-1:0]        o_z,
    output logic [SIDE_W-1:0]                   o_side
);
    import bhdti_pkg::*;

    localparam int PW = VEC_W + 32;

    logic                    w_neg;
    logic                    r_v  [0:STEPS];
    logic signed [VEC_W-1:0] r_x  [0:STEPS];
    logic signed [VEC_W-1:0] r_y  [0:STEPS];
    logic signed [VEC_W-1:0] r_fx [0:STEPS];
    logic signed [VEC_W-1:0] r_fy [0:STEPS];
    logic [TURN_W-1:0]       r_z  [0:STEPS];
    logic [SIDE_W-1:0]       r_s  [0:STEPS];

    logic signed [PW-1:0]    w_px, w_pfx, w_pfy;
    logic                    r_vo;
    logic signed [VEC_W-1:0] r_xo, r_fxo, r_fyo;
    logic [TURN_W-1:0]       r_zo;
    logic [SIDE_W-1:0]       r_so;

    // left half-plane: turn by a half turn first
    assign w_neg = i_x[VEC_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= w_neg ? -i_x  : i_x;
            r_y[0]  <= w_neg ? -i_y  : i_y;
            r_fx[0] <= w_neg ? -i_fx : i_fx;
            r_fy[0] <= w_neg ? -i_fy : i_fy;
            r_z[0]  <= w_neg ? HALF_TURN : '0;
            r_s[0]  <= i_side;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [TURN_W-1:0] ANG = f_atan(i);
        logic signed [VEC_W-1:0] n_x, n_y, n_fx, n_fy;
        logic [TURN_W-1:0]       n_z;

        always_comb begin
            if (!r_y[i][VEC_W-1]) begin
                n_x  = r_x[i]  + (r_y[i]  >>> i);
                n_y  = r_y[i]  - (r_x[i]  >>> i);
                n_fx = r_fx[i] + (r_fy[i] >>> i);
                n_fy = r_fy[i] - (r_fx[i] >>> i);
                n_z  = r_z[i]  + ANG;
            end else begin
                n_x  = r_x[i]  - (r_y[i]  >>> i);
                n_y  = r_y[i]  + (r_x[i]  >>> i);
                n_fx = r_fx[i] - (r_fy[i] >>> i);
                n_fy = r_fy[i] + (r_fx[i] >>> i);
                n_z  = r_z[i]  - ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]  <= n_x;
                r_y[i+1]  <= n_y;
                r_fx[i+1] <= n_fx;
                r_fy[i+1] <= n_fy;
                r_z[i+1]  <= n_z;
                r_s[i+1]  <= r_s[i];
            end
        end
    end

    // gain correction, floor rounding
    assign w_px  = PW'(r_x[STEPS])  * PW'(INV_GAIN);
    assign w_pfx = PW'(r_fx[STEPS]) * PW'(INV_GAIN);
    assign w_pfy = PW'(r_fy[STEPS]) * PW'(INV_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xo  <= w_px[VEC_W+QFRAC-1:QFRAC];
            r_fxo <= w_pfx[VEC_W+QFRAC-1:QFRAC];
            r_fyo <= w_pfy[VEC_W+QFRAC-1:QFRAC];
            r_zo  <= r_z[STEPS];
            r_so  <= r_s[STEPS];
        end
    end

    assign o_valid = r_vo;
    assign o_x     = r_xo;
    assign o_fx    = r_fxo;
    assign o_fy    = r_fyo;
    assign o_z     = r_zo;
    assign o_side  = r_so;

endmodule

>>> design/bhdti_bin.sv
// Angle binning (square-root, linear, folded) and table address generation.
module bhdti_bin #(
    parameter int HALF_POLAR_BINS  = bhdti_pkg::HALF_POLAR_BINS_DEF,
    parameter int DIFF_POLAR_BINS  = bhdti_pkg::DIFF_POLAR_BINS_DEF,
    parameter int DIFF_AZIMUTH_RES = bhdti_pkg::DIFF_AZIMUTH_RES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bhdti_pkg::TURN_W-1:0]  i_th,
    input  logic [bhdti_pkg::TURN_W-1:0]  i_td,
    input  logic [bhdti_pkg::TURN_W-1:0]  i_pd,
    output logic                          o_valid,
    output logic [bhdti_pkg::HPB_W-1:0]   o_half_polar_bin,
    output logic [bhdti_pkg::DPB_W-1:0]   o_diff_polar_bin,
    output logic [bhdti_pkg::DAB_W-1:0]   o_diff_azimuth_bin,
    output logic [bhdti_pkg::RED_W-1:0]   o_red_address,
    output logic [bhdti_pkg::GRN_W-1:0]   o_green_address,
    output logic [bhdti_pkg::BLU_W-1:0]   o_blue_address
);
    import bhdti_pkg::*;

    localparam int HALF_RES = DIFF_AZIMUTH_RES / 2;
    localparam int HB_SQ    = HALF_POLAR_BINS * HALF_POLAR_BINS;
    localparam int SQ_W     = (TURN_W - 1) + $clog2(HB_SQ + 1);
    localparam int RT_W     = (SQ_W + 1) / 2;
    localparam int PW       = TURN_W + 10;
    localparam int ROW      = HALF_RES * DIFF_POLAR_BINS;
    localparam int PLANE    = HALF_POLAR_BINS * ROW;

    logic [PW-1:0]    w_tdp, w_pdp;
    logic [PW-1:0]    w_raw_d, w_raw_p;
    logic [SQ_W-1:0]  w_sq;
    logic [BIN_W-1:0] w_bd, w_bp;

    logic             r_sval [0:RT_W];
    logic [SQ_W-1:0]  r_sv   [0:RT_W];
    logic [SQ_W:0]    r_sr   [0:RT_W];
    logic [BIN_W-1:0] r_sbd  [0:RT_W];
    logic [BIN_W-1:0] r_sbp  [0:RT_W];

    logic [SQ_W:0]     w_raw_h;
    logic [BIN_W-1:0]  w_bh;
    logic              r_x_v, r_y_v, r_z_v;
    logic [BIN_W-1:0]  r_x_bh, r_x_bd, r_x_bp, r_y_bh, r_y_bd, r_y_bp;
    logic [BIN_W-1:0]  r_z_bh, r_z_bd, r_z_bp;
    logic [ADDR_W-1:0] r_x_t1, r_y_addr;
    logic [ADDR_W-1:0] r_z_red, r_z_grn, r_z_blu;

    assign w_tdp   = PW'(i_td) * PW'(DIFF_POLAR_BINS);
    assign w_pdp   = PW'(i_pd[TURN_W-2:0]) * PW'(HALF_RES);
    assign w_raw_d = w_tdp >> QFRAC;
    assign w_raw_p = w_pdp >> (TURN_W - 1);
    assign w_sq    = SQ_W'(i_th[TURN_W-2:0]) * SQ_W'(HB_SQ);

    // negative polar angle gives bin 0; folding drops the top bit of phi
    always_comb begin
        if (i_td[TURN_W-1]) begin
            w_bd = '0;
        end else if (w_raw_d > PW'(DIFF_POLAR_BINS - 1)) begin
            w_bd = BIN_W'(DIFF_POLAR_BINS - 1);
        end else begin
            w_bd = w_raw_d[BIN_W-1:0];
        end
        if (w_raw_p > PW'(HALF_RES - 1)) begin
            w_bp = BIN_W'(HALF_RES - 1);
        end else begin
            w_bp = w_raw_p[BIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sval[0] <= 1'b0;
        end else if (i_en) begin
            r_sval[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv[0]  <= i_th[TURN_W-1] ? '0 : w_sq;
            r_sr[0]  <= '0;
            r_sbd[0] <= w_bd;
            r_sbp[0] <= w_bp;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
        localparam logic [SQ_W:0] BITV = (SQ_W+1)'(1) << (2 * (RT_W - 1 - k));
        logic [SQ_W:0]   n_t;
        logic            n_ge;
        logic [SQ_W-1:0] n_v;
        logic [SQ_W:0]   n_r;

        assign n_t  = r_sr[k] + BITV;
        assign n_ge = {1'b0, r_sv[k]} >= n_t;
        assign n_v  = n_ge ? (r_sv[k] - n_t[SQ_W-1:0]) : r_sv[k];
        assign n_r  = n_ge ? ((r_sr[k] >> 1) + BITV) : (r_sr[k] >> 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sval[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sval[k+1] <= r_sval[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sv[k+1]  <= n_v;
                r_sr[k+1]  <= n_r;
                r_sbd[k+1] <= r_sbd[k];
                r_sbp[k+1] <= r_sbp[k];
            end
        end
    end

    assign w_raw_h = r_sr[RT_W] >> SQ_SHIFT;
    assign w_bh    = (w_raw_h > (SQ_W+1)'(HALF_POLAR_BINS - 1)) ?
                     BIN_W'(HALF_POLAR_BINS - 1) : w_raw_h[BIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
            r_y_v <= 1'b0;
            r_z_v <= 1'b0;
        end else if (i_en) begin
            r_x_v <= r_sval[RT_W];
            r_y_v <= r_x_v;
            r_z_v <= r_y_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_bh   <= w_bh;
            r_x_bd   <= r_sbd[RT_W];
            r_x_bp   <= r_sbp[RT_W];
            r_x_t1   <= ADDR_W'(r_sbp[RT_W]) + ADDR_W'(r_sbd[RT_W]) * ADDR_W'(HALF_RES);
            r_y_bh   <= r_x_bh;
            r_y_bd   <= r_x_bd;
            r_y_bp   <= r_x_bp;
            r_y_addr <= r_x_t1 + ADDR_W'(r_x_bh) * ADDR_W'(ROW);
            r_z_bh   <= r_y_bh;
            r_z_bd   <= r_y_bd;
            r_z_bp   <= r_y_bp;
            r_z_red  <= r_y_addr;
            r_z_grn  <= r_y_addr + ADDR_W'(PLANE);
            r_z_blu  <= r_y_addr + ADDR_W'(2 * PLANE);
        end
    end

    assign o_valid            = r_z_v;
    assign o_half_polar_bin   = r_z_bh[HPB_W-1:0];
    assign o_diff_polar_bin   = r_z_bd[DPB_W-1:0];
    assign o_diff_azimuth_bin = r_z_bp[DAB_W-1:0];
    assign o_red_address      = r_z_red[RED_W-1:0];
    assign o_green_address    = r_z_grn[GRN_W-1:0];
    assign o_blue_address     = r_z_blu[BLU_W-1:0];

`ifndef SYNTHESIS
    a_bh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_z_v |-> (r_z_bh <= BIN_W'(HALF_POLAR_BINS - 1)))
        else $error("half polar bin out of range");
    a_bd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_z_v |-> (r_z_bd <= BIN_W'(DIFF_POLAR_BINS - 1)))
        else $error("diff polar bin out of range");
    a_bp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_z_v |-> (r_z_bp <= BIN_W'(HALF_RES - 1)))
        else $error("diff azimuth bin out of range");
    a_green_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_z_v |-> (r_z_grn - r_z_red == ADDR_W'(PLANE)))
        else $error("green address not one plane above red");
`endif

endmodule

>>> design/brdf_half_diff_table_index.sv
// Top level: direction pair to half/difference angle bins and table addresses.
// Takes an incoming and an outgoing direction (polar and azimuth as turn fractions)
// and returns the half-vector polar bin, the difference polar bin and the folded
// difference azimuth bin plus the red, green and blue table addresses. Fully
// pipelined: while the output is not stalled, one transaction is accepted every
// clock and results leave in order, one per clock. The path runs through the sin/cos
// CORDIC, the direction products and half vector sum, four chained vectoring CORDIC
// passes, then binning, an R-stage square root and the address adds, where
// R = ceil((31 + clog2(HALF_POLAR_BINS^2 + 1)) / 2).
// When the output transaction is stalled the whole pipeline holds and o_stall rises.
module brdf_half_diff_table_index #(
    parameter int HALF_POLAR_BINS  = bhdti_pkg::HALF_POLAR_BINS_DEF,
    parameter int DIFF_POLAR_BINS  = bhdti_pkg::DIFF_POLAR_BINS_DEF,
    parameter int DIFF_AZIMUTH_RES = bhdti_pkg::DIFF_AZIMUTH_RES_DEF,
    parameter int ANGLE_BITS       = bhdti_pkg::ANGLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ANGLE_BITS-2:0]         i_incoming_polar,
    input  logic [ANGLE_BITS-1:0]         i_incoming_azimuth,
    input  logic [ANGLE_BITS-2:0]         i_outgoing_polar,
    input  logic [ANGLE_BITS-1:0]         i_outgoing_azimuth,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bhdti_pkg::HPB_W-1:0]   o_half_polar_bin,
    output logic [bhdti_pkg::DPB_W-1:0]   o_diff_polar_bin,
    output logic [bhdti_pkg::DAB_W-1:0]   o_diff_azimuth_bin,
    output logic [bhdti_pkg::RED_W-1:0]   o_red_address,
    output logic [bhdti_pkg::GRN_W-1:0]   o_green_address,
    output logic [bhdti_pkg::BLU_W-1:0]   o_blue_address
);
    import bhdti_pkg::*;

    localparam logic [ANGLE_BITS-2:0] POL_QUARTER = {1'b1, {(ANGLE_BITS-2){1'b0}}};
    localparam int TSH = TURN_W - ANGLE_BITS;

    logic w_en;
    logic [ANGLE_BITS-2:0] w_pi, w_po;
    logic [TURN_W-1:0] w_tpi, w_tai, w_tpo, w_tao;

    logic w_rot_v;
    logic signed [ROT_W-1:0] w_cpi, w_spi, w_cai, w_sai, w_cpo, w_spo, w_cao, w_sao;
    logic signed [2*ROT_W-1:0] w_pix, w_piy, w_pox, w_poy;

    logic r_m_v, r_s_v;
    logic signed [VEC_W-1:0] r_vix, r_viy, r_viz, r_vox, r_voy, r_voz;
    logic signed [VEC_W-1:0] r_hx, r_hy, r_hz, r_ix, r_iy, r_iz;

    logic w_v1_v, w_v2_v, w_v3_v, w_v4_v;
    logic signed [VEC_W-1:0] w_v1_x, w_v1_fx, w_v1_fy;
    logic [2*VEC_W-1:0] w_v1_side;
    logic signed [VEC_W-1:0] w_v2_fx, w_v2_fy, w_v2_side;
    logic [TURN_W-1:0] w_th;
    logic signed [VEC_W-1:0] w_v3_x;
    logic [TURN_W-1:0] w_pd;
    logic [VEC_W+TURN_W-1:0] w_v3_side;
    logic [TURN_W-1:0] w_td;
    logic [2*TURN_W-1:0] w_v4_side;

    // the pipeline only holds while a finished result is refused
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // polar clamps to a quarter turn, azimuth wraps
    assign w_pi  = (i_incoming_polar > POL_QUARTER) ? POL_QUARTER : i_incoming_polar;
    assign w_po  = (i_outgoing_polar > POL_QUARTER) ? POL_QUARTER : i_outgoing_polar;
    assign w_tpi = TURN_W'(w_pi) << TSH;
    assign w_tpo = TURN_W'(w_po) << TSH;
    assign w_tai = TURN_W'(i_incoming_azimuth) << TSH;
    assign w_tao = TURN_W'(i_outgoing_azimuth) << TSH;

    bhdti_rot_cordic u_rot_pi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid && w_en),
        .i_angle(w_tpi), .o_valid(w_rot_v), .o_cos(w_cpi), .o_sin(w_spi)
    );
    bhdti_rot_cordic u_rot_ai (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid && w_en),
        .i_angle(w_tai), .o_valid(), .o_cos(w_cai), .o_sin(w_sai)
    );
    bhdti_rot_cordic u_rot_po (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid && w_en),
        .i_angle(w_tpo), .o_valid(), .o_cos(w_cpo), .o_sin(w_spo)
    );
    bhdti_rot_cordic u_rot_ao (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid && w_en),
        .i_angle(w_tao), .o_valid(), .o_cos(w_cao), .o_sin(w_sao)
    );

    assign w_pix = (2*ROT_W)'(w_spi) * (2*ROT_W)'(w_cai);
    assign w_piy = (2*ROT_W)'(w_spi) * (2*ROT_W)'(w_sai);
    assign w_pox = (2*ROT_W)'(w_spo) * (2*ROT_W)'(w_cao);
    assign w_poy = (2*ROT_W)'(w_spo) * (2*ROT_W)'(w_sao);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= w_rot_v;
            r_s_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vix <= VEC_W'($signed(w_pix[ROT_W+QFRAC-1:QFRAC]));
            r_viy <= VEC_W'($signed(w_piy[ROT_W+QFRAC-1:QFRAC]));
            r_viz <= VEC_W'(w_cpi);
            r_vox <= VEC_W'($signed(w_pox[ROT_W+QFRAC-1:QFRAC]));
            r_voy <= VEC_W'($signed(w_poy[ROT_W+QFRAC-1:QFRAC]));
            r_voz <= VEC_W'(w_cpo);
            r_hx  <= r_vix + r_vox;
            r_hy  <= r_viy + r_voy;
            r_hz  <= r_viz + r_voz;
            r_ix  <= r_vix;
            r_iy  <= r_viy;
            r_iz  <= r_viz;
        end
    end

    // half vector azimuth: carry the incoming vector into its plane
    bhdti_vec_cordic #(.SIDE_W(2*VEC_W)) u_vec_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_s_v),
        .i_x(r_hx), .i_y(r_hy), .i_fx(r_ix), .i_fy(r_iy), .i_side({r_hz, r_iz}),
        .o_valid(w_v1_v), .o_x(w_v1_x), .o_fx(w_v1_fx), .o_fy(w_v1_fy), .o_z(),
        .o_side(w_v1_side)
    );

    // half-vector polar angle; followers become the difference vector's z and x
    bhdti_vec_cordic #(.SIDE_W(VEC_W)) u_vec_th (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v1_v),
        .i_x($signed(w_v1_side[2*VEC_W-1:VEC_W])), .i_y(w_v1_x),
        .i_fx($signed(w_v1_side[VEC_W-1:0])), .i_fy(w_v1_fx), .i_side(w_v1_fy),
        .o_valid(w_v2_v), .o_x(), .o_fx(w_v2_fx), .o_fy(w_v2_fy), .o_z(w_th),
        .o_side(w_v2_side)
    );

    // difference azimuth
    bhdti_vec_cordic #(.SIDE_W(VEC_W+TURN_W)) u_vec_pd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v2_v),
        .i_x(w_v2_fy), .i_y(w_v2_side), .i_fx('0), .i_fy('0),
        .i_side({w_v2_fx, w_th}),
        .o_valid(w_v3_v), .o_x(w_v3_x), .o_fx(), .o_fy(), .o_z(w_pd),
        .o_side(w_v3_side)
    );

    // difference polar angle
    bhdti_vec_cordic #(.SIDE_W(2*TURN_W)) u_vec_td (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v3_v),
        .i_x($signed(w_v3_side[VEC_W+TURN_W-1:TURN_W])), .i_y(w_v3_x),
        .i_fx('0), .i_fy('0), .i_side({w_v3_side[TURN_W-1:0], w_pd}),
        .o_valid(w_v4_v), .o_x(), .o_fx(), .o_fy(), .o_z(w_td),
        .o_side(w_v4_side)
    );

    bhdti_bin #(
        .HALF_POLAR_BINS(HALF_POLAR_BINS),
        .DIFF_POLAR_BINS(DIFF_POLAR_BINS),
        .DIFF_AZIMUTH_RES(DIFF_AZIMUTH_RES)
    ) u_bin (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v4_v),
        .i_th(w_v4_side[2*TURN_W-1:TURN_W]), .i_td(w_td),
        .i_pd(w_v4_side[TURN_W-1:0]),
        .o_valid(o_valid),
        .o_half_polar_bin(o_half_polar_bin),
        .o_diff_polar_bin(o_diff_polar_bin),
        .o_diff_azimuth_bin(o_diff_azimuth_bin),
        .o_red_address(o_red_address),
        .o_green_address(o_green_address),
        .o_blue_address(o_blue_address)
    );

endmodule
